// ===== hw/rtl/omrp_pkg.sv =====
// ----------------------------------------------------------------------------
// omrp_pkg - shared types and constants for the mode 41 response parser
// Request/response payloads, classified character item, keyword tables.
// ----------------------------------------------------------------------------
package omrp_pkg;

  localparam int MAX_TOKENS_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;
  localparam int NUM_KW         = 4;
  localparam int KW_MAX_LEN     = 8;

  localparam logic [7:0] SERVICE_BYTE = 8'h41;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAX_LEN] = '{
    '{"N", "O", " ", "D", "A", "T", "A", 8'h00},
    '{"E", "R", "R", "O", "R", 8'h00, 8'h00, 8'h00},
    '{"U", "N", "A", "B", "L", "E", 8'h00, 8'h00},
    '{"S", "T", "O", "P", "P", "E", "D", 8'h00}
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd7, 3'd5, 3'd6, 3'd7};

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [7:0] value_a;
    logic [7:0] value_b;
  } rsp_t;

  // One character after upper-casing and classification
  typedef struct packed {
    logic [7:0] chr;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_sep;
    logic       is_colon;
    logic       is_ws;
    logic       last;
  } item_t;

  // Longest keyword prefix that ends at the new character, given q matched
  function automatic logic [2:0] kw_next(input int kw, input logic [2:0] q,
                                         input logic [7:0] c);
    logic [2:0] res;
    logic       found;
    logic       ok;
    int         idx;
    res   = 3'd0;
    found = 1'b0;
    for (int k = KW_MAX_LEN - 1; k >= 1; k--) begin
      if (!found && (k <= int'(q) + 1)) begin
        ok = (KW_TEXT[kw][k-1] == c);
        for (int j = 0; j < KW_MAX_LEN - 2; j++) begin
          if (j + 1 < k) begin
            idx = int'(q) + 1 - k + j;
            if (idx >= 0 && idx < KW_MAX_LEN) begin
              if (KW_TEXT[kw][j] != KW_TEXT[kw][idx]) ok = 1'b0;
            end
          end
        end
        if (ok) begin
          res   = 3'(k);
          found = 1'b1;
        end
      end
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/omrp_front.sv =====
// ----------------------------------------------------------------------------
// omrp_front - character classifier
// Upper-cases the incoming character and tags hex, separator, colon and
// blank classes for the parsing back end.
// ----------------------------------------------------------------------------
module omrp_front
  import omrp_pkg::*;
(
  input  req_t  req_data,
  output item_t item
);

  logic [7:0] up;

  always_comb begin
    up = req_data.char_code;
    if (up >= "a" && up <= "z") begin
      up = up - 8'd32;
    end
    item          = '0;
    item.chr      = up;
    item.last     = req_data.last_char;
    item.is_sep   = (up == CH_SPACE) || (up == CH_LF);
    item.is_colon = (up == CH_COLON);
    item.is_ws    = (up == CH_TAB) || (up == CH_VT) || (up == CH_FF) || (up == CH_CR);
    if (up >= "0" && up <= "9") begin
      item.is_hex  = 1'b1;
      item.hex_val = 4'(up - "0");
    end else if (up >= "A" && up <= "F") begin
      item.is_hex  = 1'b1;
      item.hex_val = 4'(up - "A" + 8'd10);
    end
  end

endmodule

// ===== hw/rtl/omrp_queue.sv =====
// ----------------------------------------------------------------------------
// omrp_queue - short item queue
// Decouples the classifier from the parser so either side can stall alone.
// ----------------------------------------------------------------------------
module omrp_queue
  import omrp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_valid,
  output logic  wr_stall,
  input  item_t wr_item,
  output logic  rd_valid,
  input  logic  rd_pop,
  output item_t rd_item
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t         store [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;

  assign wr_stall = (count == CW'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = store[rd_ptr];
  assign push     = wr_valid && !wr_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !rd_pop) begin
        count <= count + 1'b1;
      end else if (!push && rd_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/omrp_back.sv =====
// ----------------------------------------------------------------------------
// omrp_back - response parser
// Keyword matchers, packed hex byte search and token search; emits one
// response on the last character through a registered output stage.
// ----------------------------------------------------------------------------
module omrp_back
  import omrp_pkg::*;
#(
  parameter int MAX_TOKENS = MAX_TOKENS_DEF
)
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] expected_pid,
  input  logic       item_valid,
  input  item_t      item,
  output logic       item_pop,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output rsp_t       rsp_data
);

  localparam int TCW = $clog2(MAX_TOKENS + 1);

  typedef enum logic [1:0] {
    PROG_SEARCH,
    PROG_HAVE_A,
    PROG_HAVE_B
  } prog_t;

  // keyword state
  logic [2:0]     kw_q [NUM_KW];
  logic [2:0]     kw_q_next [NUM_KW];
  logic           kw_seen, kw_seen_next;
  // packed search state
  logic           pk_odd, pk_odd_next;
  logic [3:0]     pk_hi, pk_hi_next;
  logic [7:0]     pk_win [2];
  logic [7:0]     pk_win_next [2];
  logic [1:0]     pk_fill, pk_fill_next;
  prog_t          pk_prog, pk_prog_next;
  logic [7:0]     pk_a, pk_a_next, pk_b, pk_b_next;
  // token search state
  logic [7:0]     tk_acc, tk_acc_next;
  logic [1:0]     tk_cc, tk_cc_next;
  logic           tk_open, tk_open_next;
  logic           tk_started, tk_started_next;
  logic [7:0]     tk_win [2];
  logic [7:0]     tk_win_next [2];
  logic [1:0]     tk_fill, tk_fill_next;
  logic [TCW-1:0] tk_count, tk_count_next;
  prog_t          tk_prog, tk_prog_next;
  logic [7:0]     tk_a, tk_a_next, tk_b, tk_b_next;

  logic [7:0]     pk_byte;
  logic           tk_take;
  rsp_t           result;

  assign item_pop = item_valid && (!item.last || !rsp_valid || !rsp_stall);

  always_comb begin
    kw_seen_next = kw_seen;
    for (int i = 0; i < NUM_KW; i++) begin
      kw_q_next[i] = kw_next(i, kw_q[i], item.chr);
      if (kw_q_next[i] >= KW_LEN[i]) begin
        kw_seen_next = 1'b1;
        kw_q_next[i] = 3'd0;
      end
    end

    // packed hex stream: pair nibbles into bytes, slide the 41,PID window
    pk_odd_next  = pk_odd;
    pk_hi_next   = pk_hi;
    pk_win_next  = pk_win;
    pk_fill_next = pk_fill;
    pk_prog_next = pk_prog;
    pk_a_next    = pk_a;
    pk_b_next    = pk_b;
    pk_byte      = {pk_hi, item.hex_val};
    if (item.is_hex) begin
      if (pk_odd) begin
        pk_odd_next = 1'b0;
        case (pk_prog)
          PROG_SEARCH: begin
            if (pk_fill == 2'd2 && pk_win[0] == SERVICE_BYTE && pk_win[1] == expected_pid) begin
              pk_a_next    = pk_byte;
              pk_prog_next = PROG_HAVE_A;
            end
          end
          PROG_HAVE_A: begin
            pk_b_next    = pk_byte;
            pk_prog_next = PROG_HAVE_B;
          end
          default: ;
        endcase
        pk_win_next[0] = pk_win[1];
        pk_win_next[1] = pk_byte;
        if (pk_fill != 2'd2) pk_fill_next = pk_fill + 1'b1;
      end else begin
        pk_odd_next = 1'b1;
        pk_hi_next  = item.hex_val;
      end
    end

    // token build; skip colons ahead of the first character
    tk_acc_next     = tk_acc;
    tk_cc_next      = tk_cc;
    tk_open_next    = tk_open;
    tk_started_next = tk_started;
    if (!item.is_sep && !(item.is_colon && !tk_started)) begin
      tk_started_next = 1'b1;
      if (item.is_ws) begin
        if (tk_cc != 2'd0) tk_open_next = 1'b0;
      end else begin
        tk_cc_next = (tk_cc == 2'd0) ? 2'd1 : 2'd2;
        if (tk_open && item.is_hex) begin
          tk_acc_next = {tk_acc[3:0], item.hex_val};
        end else begin
          tk_open_next = 1'b0;
        end
      end
    end

    // close the token on a separator or the last character
    tk_win_next   = tk_win;
    tk_fill_next  = tk_fill;
    tk_count_next = tk_count;
    tk_prog_next  = tk_prog;
    tk_a_next     = tk_a;
    tk_b_next     = tk_b;
    tk_take       = (item.is_sep || item.last) && tk_started_next && (tk_cc_next == 2'd2)
                    && (tk_count < TCW'(MAX_TOKENS));
    if (tk_take) begin
      case (tk_prog)
        PROG_SEARCH: begin
          if (tk_fill == 2'd2 && tk_win[0] == SERVICE_BYTE && tk_win[1] == expected_pid) begin
            tk_a_next    = tk_acc_next;
            tk_prog_next = PROG_HAVE_A;
          end
        end
        PROG_HAVE_A: begin
          tk_b_next    = tk_acc_next;
          tk_prog_next = PROG_HAVE_B;
        end
        default: ;
      endcase
      tk_win_next[0] = tk_win[1];
      tk_win_next[1] = tk_acc_next;
      if (tk_fill != 2'd2) tk_fill_next = tk_fill + 1'b1;
      tk_count_next = tk_count + 1'b1;
    end
    if (item.is_sep || item.last) begin
      tk_acc_next     = 8'd0;
      tk_cc_next      = 2'd0;
      tk_open_next    = 1'b1;
      tk_started_next = 1'b0;
    end

    result = '0;
    if (!kw_seen_next) begin
      if (pk_prog_next != PROG_SEARCH) begin
        result.found   = 1'b1;
        result.value_a = pk_a_next;
        result.value_b = pk_b_next;
      end else if (tk_prog_next != PROG_SEARCH) begin
        result.found   = 1'b1;
        result.value_a = tk_a_next;
        result.value_b = tk_b_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (item_pop && item.last)) begin
      for (int i = 0; i < NUM_KW; i++) kw_q[i] <= 3'd0;
      kw_seen    <= 1'b0;
      pk_odd     <= 1'b0;
      pk_hi      <= 4'd0;
      pk_win[0]  <= 8'd0;
      pk_win[1]  <= 8'd0;
      pk_fill    <= 2'd0;
      pk_prog    <= PROG_SEARCH;
      pk_a       <= 8'd0;
      pk_b       <= 8'd0;
      tk_acc     <= 8'd0;
      tk_cc      <= 2'd0;
      tk_open    <= 1'b1;
      tk_started <= 1'b0;
      tk_win[0]  <= 8'd0;
      tk_win[1]  <= 8'd0;
      tk_fill    <= 2'd0;
      tk_count   <= '0;
      tk_prog    <= PROG_SEARCH;
      tk_a       <= 8'd0;
      tk_b       <= 8'd0;
    end else if (item_pop) begin
      kw_q       <= kw_q_next;
      kw_seen    <= kw_seen_next;
      pk_odd     <= pk_odd_next;
      pk_hi      <= pk_hi_next;
      pk_win     <= pk_win_next;
      pk_fill    <= pk_fill_next;
      pk_prog    <= pk_prog_next;
      pk_a       <= pk_a_next;
      pk_b       <= pk_b_next;
      tk_acc     <= tk_acc_next;
      tk_cc      <= tk_cc_next;
      tk_open    <= tk_open_next;
      tk_started <= tk_started_next;
      tk_win     <= tk_win_next;
      tk_fill    <= tk_fill_next;
      tk_count   <= tk_count_next;
      tk_prog    <= tk_prog_next;
      tk_a       <= tk_a_next;
      tk_b       <= tk_b_next;
    end
  end

  // output stage: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (item_pop && item.last) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop && item.last) begin
      rsp_data <= result;
    end
  end

endmodule

// ===== hw/rtl/obd_mode41_response_parser.sv =====
// ----------------------------------------------------------------------------
// obd_mode41_response_parser - mode 41 reply parser
// One adapter character per request; one response per reply text.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle, except that a last character waits while a previous response is stalled.
// Response: the last character is written into the queue, then parsed and registered in the output stage when popped.
// Reset: synchronous; clears queue, parser state, output and expected_pid.
// Parser state returns to its reset values after every response.
module obd_mode41_response_parser
  import omrp_pkg::*;
#(
  parameter int MAX_TOKENS = MAX_TOKENS_DEF
)
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  req_t       req_data,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output rsp_t       rsp_data,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic [7:0] expected_pid;
  item_t      front_item;
  item_t      q_item;
  logic       q_valid;
  logic       q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_pid <= 8'd0;
    end else if (cfg_wr_en) begin
      expected_pid <= cfg_wr_data;
    end
  end

  omrp_front u_front (
    .req_data (req_data),
    .item     (front_item)
  );

  omrp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (req_valid),
    .wr_stall (req_stall),
    .wr_item  (front_item),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_item  (q_item)
  );

  omrp_back #(
    .MAX_TOKENS (MAX_TOKENS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .expected_pid (expected_pid),
    .item_valid   (q_valid),
    .item         (q_item),
    .item_pop     (q_pop),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp_data     (rsp_data)
  );

endmodule
